// ----- src/quaternion_to_rotation_matrix_defines.svh -----
// Assertion macros shared by the quaternion to rotation matrix RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QRM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrm assertion failed");

// next-cycle implication, disabled in reset
`define QRM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrm assertion failed");

`endif

// ----- src/qrm_pkg.sv -----
// Package for the quaternion to rotation matrix block: widths, pipeline
// sizing and the request/result payload structs. No dependencies.
`timescale 1ns / 1ps
package qrm_pkg;
    localparam int CW    = 16;             // component width
    localparam int FRAC  = CW - 1;         // fraction bits
    localparam int PW    = 2 * CW;         // product width
    localparam int SW    = 2 * CW + 1;     // norm sum width
    localparam int NW    = 2 * CW + 2;     // signed numerator width
    localparam int RW    = SW;             // remainder width
    localparam int STEPS = FRAC + 1;       // quotient bits plus rounding bit
    localparam int SPS   = 2;              // divide steps per stage
    localparam int ND    = (STEPS + SPS - 1) / SPS;
    localparam int NE    = 9;              // matrix entries

    localparam logic [CW-1:0] MAX_POS = {1'b0, {FRAC{1'b1}}};
    localparam logic [CW-1:0] MIN_NEG = {1'b1, {FRAC{1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic signed [CW-1:0] qz;
        logic signed [CW-1:0] qw;
    } t_quat;

    typedef struct packed {
        logic signed [CW-1:0] m00;
        logic signed [CW-1:0] m01;
        logic signed [CW-1:0] m02;
        logic signed [CW-1:0] m10;
        logic signed [CW-1:0] m11;
        logic signed [CW-1:0] m12;
        logic signed [CW-1:0] m20;
        logic signed [CW-1:0] m21;
        logic signed [CW-1:0] m22;
        logic                 invalid;
    } t_matrix;
endpackage

// ----- src/qrm_lane.sv -----
// One matrix entry: magnitude/saturation stage, pipelined restoring divide
// by the norm sum, and rounding to a Q1.15 code. Depends on qrm_pkg.
`timescale 1ns / 1ps
module qrm_lane
    import qrm_pkg::*;
(
    input  logic                     i_clk,
    input  logic [ND:0]              i_en,
    input  logic signed [NW-1:0]     i_num,
    input  logic [SW-1:0]            i_s,
    input  logic [ND-1:0][SW-1:0]    i_s_st,
    output logic signed [CW-1:0]     o_code
);
    logic [RW-1:0] r_rem [0:ND];
    logic [CW-1:0] r_qb  [0:ND];
    logic          r_neg [0:ND];
    logic          r_sat [0:ND];

    logic [RW-1:0] w_mag;
    logic [CW-1:0] w_q;

    // magnitude never exceeds 2^32, so it fits the remainder width
    assign w_mag = i_num[NW-1] ? RW'(-i_num) : RW'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg[0] <= i_num[NW-1];
            r_sat[0] <= (w_mag >= i_s);
            r_rem[0] <= w_mag;
            r_qb[0]  <= '0;
        end
    end

    for (genvar d = 0; d < ND; d++) begin : g_div
        logic [RW-1:0] n_rem;
        logic [CW-1:0] n_qb;

        always_comb begin
            logic [RW:0] t;
            n_rem = r_rem[d];
            n_qb  = r_qb[d];
            t     = '0;
            for (int k = 0; k < SPS; k++) begin
                if (d * SPS + k < STEPS) begin
                    t = {n_rem, 1'b0};
                    if (t >= {1'b0, i_s_st[d]}) begin
                        t    = t - {1'b0, i_s_st[d]};
                        n_qb = {n_qb[CW-2:0], 1'b1};
                    end else begin
                        n_qb = {n_qb[CW-2:0], 1'b0};
                    end
                    n_rem = t[RW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[d+1]) begin
                r_rem[d+1] <= n_rem;
                r_qb[d+1]  <= n_qb;
                r_neg[d+1] <= r_neg[d];
                r_sat[d+1] <= r_sat[d];
            end
        end
    end

    // last quotient bit is the half-LSB: round half away from zero
    assign w_q = {1'b0, r_qb[ND][CW-1:1]} + CW'(r_qb[ND][0]);

    always_comb begin
        if (r_sat[ND]) begin
            o_code = r_neg[ND] ? MIN_NEG : MAX_POS;
        end else if (r_neg[ND]) begin
            o_code = -w_q;
        end else begin
            o_code = (w_q > MAX_POS) ? MAX_POS : w_q;
        end
    end
endmodule

// ----- src/quaternion_to_rotation_matrix.sv -----
// Pipeline from request to result:
// multiply, sum, magnitude/compare, ND divide stages of two bits, output register.
// Throughput: one request per cycle while o_stall is low; each stage holds only when its successor is full.
// Reset: synchronous active-low clears all stage valid bits; payload is not reset.
// Depends on qrm_pkg, qrm_lane and the assertion macro header.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_defines.svh"
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_quat   i_quat,
    output logic    o_valid,
    input  logic    i_stall,
    output t_matrix o_matrix
);
    localparam int NS = ND + 4;
    localparam int SL = 2;          // first lane stage

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: pairwise products
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_xw, r_yz, r_yw, r_zw;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_xx <= i_quat.qx * i_quat.qx;
            r_yy <= i_quat.qy * i_quat.qy;
            r_zz <= i_quat.qz * i_quat.qz;
            r_ww <= i_quat.qw * i_quat.qw;
            r_xy <= i_quat.qx * i_quat.qy;
            r_xz <= i_quat.qx * i_quat.qz;
            r_xw <= i_quat.qx * i_quat.qw;
            r_yz <= i_quat.qy * i_quat.qz;
            r_yw <= i_quat.qy * i_quat.qw;
            r_zw <= i_quat.qz * i_quat.qw;
        end
    end

    // stage 1: norm sum and numerators
    logic signed [NW-1:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_xw, e_yz, e_yw, e_zw;
    logic [SW-1:0]        w_s;
    logic signed [NW-1:0] r_num [0:NE-1];
    logic [SW-1:0]        r_s1;
    logic                 r_zero1;

    assign e_xx = NW'(r_xx);
    assign e_yy = NW'(r_yy);
    assign e_zz = NW'(r_zz);
    assign e_ww = NW'(r_ww);
    assign e_xy = NW'(r_xy);
    assign e_xz = NW'(r_xz);
    assign e_xw = NW'(r_xw);
    assign e_yz = NW'(r_yz);
    assign e_yw = NW'(r_yw);
    assign e_zw = NW'(r_zw);
    assign w_s  = SW'(e_xx + e_yy + e_zz + e_ww);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_num[0] <= e_ww + e_xx - e_yy - e_zz;
            r_num[1] <= (e_xy - e_zw) <<< 1;
            r_num[2] <= (e_xz + e_yw) <<< 1;
            r_num[3] <= (e_xy + e_zw) <<< 1;
            r_num[4] <= e_ww + e_yy - e_xx - e_zz;
            r_num[5] <= (e_yz - e_xw) <<< 1;
            r_num[6] <= (e_xz - e_yw) <<< 1;
            r_num[7] <= (e_yz + e_xw) <<< 1;
            r_num[8] <= e_ww + e_zz - e_xx - e_yy;
            r_s1     <= w_s;
            r_zero1  <= (w_s == '0);
        end
    end

    // norm sum and zero flag follow the lane stages
    logic [ND-1:0][SW-1:0] r_s_st;
    logic [ND:0]           r_zero;

    always_ff @(posedge i_clk) begin
        if (en[SL]) begin
            r_s_st[0] <= r_s1;
            r_zero[0] <= r_zero1;
        end
        for (int d = 0; d < ND - 1; d++) begin
            if (en[SL+d+1]) begin
                r_s_st[d+1] <= r_s_st[d];
            end
        end
        for (int d = 0; d < ND; d++) begin
            if (en[SL+d+1]) begin
                r_zero[d+1] <= r_zero[d];
            end
        end
    end

    logic signed [CW-1:0] w_code [0:NE-1];

    for (genvar e = 0; e < NE; e++) begin : g_lane
        qrm_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en[SL +: ND+1]),
            .i_num  (r_num[e]),
            .i_s    (r_s1),
            .i_s_st (r_s_st),
            .o_code (w_code[e])
        );
    end

    // output register; zero quaternion gives identity
    t_matrix r_out;

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            if (r_zero[ND]) begin
                r_out <= '{m00: MAX_POS, m01: '0, m02: '0,
                           m10: '0, m11: MAX_POS, m12: '0,
                           m20: '0, m21: '0, m22: MAX_POS, invalid: 1'b1};
            end else begin
                r_out <= '{m00: w_code[0], m01: w_code[1], m02: w_code[2],
                           m10: w_code[3], m11: w_code[4], m12: w_code[5],
                           m20: w_code[6], m21: w_code[7], m22: w_code[8],
                           invalid: 1'b0};
            end
        end
    end

    assign o_matrix = r_out;

    `QRM_ASSERT_IMP(a_invalid_identity, o_valid && o_matrix.invalid,
        o_matrix.m00 == MAX_POS && o_matrix.m11 == MAX_POS && o_matrix.m01 == '0)
    `QRM_ASSERT_IMP(a_full_stalls_input, (&r_v) && i_stall, o_stall)
    `QRM_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_v[0])
endmodule

// ----- verif/qrm_checker.sv -----
// Checker for the quaternion to rotation matrix block: watches both channels,
// predicts each matrix from the accepted quaternion and compares. Uses qrm_pkg.
`timescale 1ns / 1ps
module qrm_checker
    import qrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_stall_in,
    input  t_quat   i_quat,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_matrix i_matrix,
    output int      o_errors,
    output int      o_pending,
    output int      o_results,
    output int      o_invalids
);
    t_matrix matrix_q[$];

    // rounded code of num/s scaled by 2^FRAC, saturating +1.0
    function automatic logic [CW-1:0] ratio_code(longint num, longint s);
        longint mag, q, r;
        logic neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag << FRAC) / s;
        r = (mag << FRAC) % s;
        if (2 * r >= s) q = q + 1;
        if (mag >= s) q = longint'(1) << FRAC;
        if (neg) return CW'(-q);
        return (q > longint'(MAX_POS)) ? MAX_POS : CW'(q);
    endfunction

    function automatic t_matrix rotate_of(t_quat q);
        longint x, y, z, w, s;
        t_matrix m;
        x = q.qx; y = q.qy; z = q.qz; w = q.qw;
        s = x*x + y*y + z*z + w*w;
        m = '0;
        if (s == 0) begin
            m.m00 = MAX_POS; m.m11 = MAX_POS; m.m22 = MAX_POS;
            m.invalid = 1'b1;
            return m;
        end
        m.m00 = ratio_code(w*w + x*x - y*y - z*z, s);
        m.m11 = ratio_code(w*w + y*y - x*x - z*z, s);
        m.m22 = ratio_code(w*w + z*z - x*x - y*y, s);
        m.m01 = ratio_code(2 * (x*y - z*w), s);
        m.m02 = ratio_code(2 * (x*z + y*w), s);
        m.m10 = ratio_code(2 * (x*y + z*w), s);
        m.m12 = ratio_code(2 * (y*z - x*w), s);
        m.m20 = ratio_code(2 * (x*z - y*w), s);
        m.m21 = ratio_code(2 * (y*z + x*w), s);
        return m;
    endfunction

    initial begin
        o_errors = 0;
        o_results = 0;
        o_invalids = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) matrix_q.push_back(rotate_of(i_quat));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (matrix_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result %h", i_matrix);
                end else begin
                    want = matrix_q.pop_front();
                    if (want.invalid) o_invalids <= o_invalids + 1;
                    if (want !== i_matrix) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected %h got %h", want, i_matrix);
                    end
                end
            end
            o_pending <= matrix_q.size();
        end
    end
endmodule

// ----- verif/tb_quaternion_to_rotation_matrix.sv -----
// Testbench top for quaternion_to_rotation_matrix: drives quaternion requests
// with random gaps and output stalls; qrm_checker does the comparison.
`timescale 1ns / 1ps
module tb_quaternion_to_rotation_matrix;
    import qrm_pkg::*;

    localparam int N_RANDOM = 1530;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    i_stall = 1'b0;
    t_quat   i_quat = '0;
    logic    o_stall, o_valid;
    t_matrix o_matrix;
    int      errors, pending, results, invalids;
    logic    hold_long = 1'b0;
    logic    sending_done = 1'b0;
    int      stall_left = 0;

    always #1 i_clk = ~i_clk;

    quaternion_to_rotation_matrix DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_quat(i_quat), .o_valid(o_valid), .i_stall(i_stall), .o_matrix(o_matrix)
    );

    qrm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_quat(i_quat), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_matrix(o_matrix), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_invalids(invalids)
    );

    function automatic logic [CW-1:0] pick_component();
        case ($urandom_range(0, 7))
            0: return MIN_NEG;
            1: return MAX_POS;
            2: return '0;
            3: return CW'($urandom_range(0, 15)) - CW'(8);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic send_quat(t_quat q);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_quat <= q;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver: draws a random wait after each accepted result, plus one long hold-off
    always @(posedge i_clk) begin
        int w;
        if (hold_long) begin
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            w = $urandom_range(0, 4);
            stall_left <= (w > 0) ? w - 1 : 0;
            i_stall <= (w != 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        #40;
        @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (60) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    initial begin
        t_quat q;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed corners: zero, identity-ish, most negative, single axes
        send_quat('{qx: 0, qy: 0, qz: 0, qw: 0});
        send_quat('{qx: 0, qy: 0, qz: 0, qw: MAX_POS});
        send_quat('{qx: 0, qy: 0, qz: 0, qw: MIN_NEG});
        send_quat('{qx: MAX_POS, qy: 0, qz: 0, qw: 0});
        send_quat('{qx: 0, qy: MIN_NEG, qz: 0, qw: 0});
        send_quat('{qx: 0, qy: 0, qz: MAX_POS, qw: 0});
        send_quat('{qx: MIN_NEG, qy: MIN_NEG, qz: MIN_NEG, qw: MIN_NEG});
        send_quat('{qx: MAX_POS, qy: MAX_POS, qz: MAX_POS, qw: MAX_POS});
        send_quat('{qx: MAX_POS, qy: MIN_NEG, qz: MAX_POS, qw: MIN_NEG});
        send_quat('{qx: 1, qy: 0, qz: 0, qw: 0});
        send_quat('{qx: 0, qy: 0, qz: 0, qw: -1});
        send_quat('{qx: 1, qy: 1, qz: 1, qw: 1});
        send_quat('{qx: -1, qy: 1, qz: -1, qw: 1});
        send_quat('{qx: 16'sd23170, qy: 0, qz: 0, qw: 16'sd23170});
        send_quat('{qx: 0, qy: 16'sd23170, qz: 0, qw: -16'sd23170});
        for (int i = 0; i < N_RANDOM; i++) begin
            q.qx = pick_component();
            q.qy = pick_component();
            q.qz = pick_component();
            q.qw = pick_component();
            if ($urandom_range(0, 40) == 0) q = '0;
            send_quat(q);
        end
        i_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    initial begin
        wait (sending_done);
        while (pending != 0) @(posedge i_clk);
        repeat (ND + 10) @(posedge i_clk);
        $display("covered %0d matrices, %0d from zero quaternions, with random gaps",
                 results, invalids);
        $display("and stalls on both channels, including one long output hold-off");
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
